// ===== hdl/audio_peak_limiter_unit_macros.svh =====
// Assertion macros shared by the peak limiter RTL.
`ifndef AUDIO_PEAK_LIMITER_UNIT_MACROS_SVH
`define AUDIO_PEAK_LIMITER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define APL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define APL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/apl_pkg.sv =====
// Types and constants of the audio peak limiter.
package apl_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int LEVEL_W    = 15;
    localparam int COEFF_W    = 16;
    localparam int GAIN_W     = 17;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // serial multiplier: 17 x 17 operands, one multiplier bit per cycle
    localparam int MUL_W      = 17;
    localparam int MUL_STEPS  = 17;
    localparam int MUL_CNT_W  = 5;

    // serial divider: one quotient bit per cycle
    localparam int DIV_W      = 16;
    localparam int DIV_STEPS  = 16;
    localparam int DIV_CNT_W  = 4;

    localparam logic [GAIN_W-1:0]  UNITY_GAIN      = 17'd65536;
    localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 15'd32767;
    localparam logic [LEVEL_W-1:0] CEILING_RESET   = 15'd32767;
    localparam logic [COEFF_W-1:0] RELEASE_RESET   = 16'd65386;
    localparam logic [GAIN_W-1:0]  MIN_GAIN_RESET  = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAIN  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_M1_GO,
        ST_M1_WAIT,
        ST_DECIDE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FLOOR,
        ST_M2_GO,
        ST_M2_WAIT,
        ST_EMIT
    } state_t;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// ===== hdl/apl_in_if.sv =====
// Sample channel: valid/ready with the input sample and frame start flag.
interface apl_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [apl_pkg::SAMPLE_W-1:0] sample_in;
    logic                                frame_start;

    modport source (output valid, output sample_in, output frame_start, input ready);
    modport sink   (input valid, input sample_in, input frame_start, output ready);
endinterface

// ===== hdl/apl_out_if.sv =====
// Result channel: valid/ready with the limited sample and applied gain.
interface apl_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [apl_pkg::SAMPLE_W-1:0] sample_out;
    logic        [apl_pkg::GAIN_W-1:0]   gain_out;

    modport source (output valid, output sample_out, output gain_out, input ready);
    modport sink   (input valid, input sample_out, input gain_out, output ready);
endinterface

// ===== hdl/audio_peak_limiter_unit.sv =====
// Peak limiter top level: config registers, sequencer and output register.
//
// Peak limiter with instant attack and exponential release on signed 16-bit
// samples. One sample is worked on at a time: it is taken on the sample
// channel while the sequencer is idle. The gain releases, or, when the
// ceiling or threshold test fires, a gain is divided out. The work is done
// by the 17-step shift-add multipliers (one pass for the ceiling test and
// release product in parallel, one pass for the output product) and the
// 16-step restoring divider. The result sits in an output register, so the
// next sample is taken while it waits. The user must see that registers are
// written on the plain write port only while the block is idle; the block
// itself does not enforce it. Index 0 threshold, 1 ceiling, 2 release
// coefficient, 3 minimum gain (values above unity act as unity).
`include "audio_peak_limiter_unit_macros.svh"

module audio_peak_limiter_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    apl_in_if.sink                             sample_ch,
    apl_out_if.source                          result_ch,
    input  logic                               cfg_we,
    input  logic [apl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [apl_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int PROD_W = 2 * apl_pkg::MUL_W;
    localparam int FW     = apl_pkg::FRAC_W;

    apl_pkg::state_t state_reg, state_next;

    logic [apl_pkg::LEVEL_W-1:0]  thr_reg;
    logic [apl_pkg::LEVEL_W-1:0]  ceil_reg;
    logic [apl_pkg::COEFF_W-1:0]  rel_reg;
    logic [apl_pkg::GAIN_W-1:0]   ming_reg;
    logic [apl_pkg::GAIN_W-1:0]   cur_gain_reg;

    logic [apl_pkg::SAMPLE_W-1:0] mag_reg;
    logic                         neg_reg;
    logic [apl_pkg::GAIN_W-1:0]   g_reg;
    logic [apl_pkg::GAIN_W-1:0]   gsel_reg;
    logic [apl_pkg::LEVEL_W-1:0]  level_reg;

    logic signed [apl_pkg::SAMPLE_W-1:0] out_sample_reg;
    logic [apl_pkg::GAIN_W-1:0]          out_gain_reg;
    logic                                out_valid_reg;

    logic                  mul0_start, mul1_start, div_start;
    logic [PROD_W-1:0]     mul0_prod, mul1_prod;
    logic [apl_pkg::DIV_W-1:0] div_q;
    apl_pkg::unit_stat_t   mul0_stat, mul1_stat, div_stat;

    logic                  accept;
    logic                  emit;
    logic                  ceil_hit;
    logic                  thr_hit;
    logic [PROD_W-1:0]     rel_sum;
    logic [apl_pkg::GAIN_W:0] rel_q;
    logic [apl_pkg::GAIN_W-1:0] rel_gain;
    logic [apl_pkg::GAIN_W-1:0] floor_g;
    logic [apl_pkg::GAIN_W-1:0] floored;
    logic [apl_pkg::SAMPLE_W-1:0] mag_in;
    logic [apl_pkg::GAIN_W-1:0] scaled;
    logic signed [apl_pkg::SAMPLE_W-1:0] y_sat;

    apl_serial_mul u_mul_mag (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul0_start),
        .op_a    ({1'b0, mag_reg}),
        .op_b    (g_reg),
        .product (mul0_prod),
        .stat    (mul0_stat)
    );

    apl_serial_mul u_mul_rel (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul1_start),
        .op_a    ({1'b0, rel_reg}),
        .op_b    (g_reg),
        .product (mul1_prod),
        .stat    (mul1_stat)
    );

    apl_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .level    (level_reg),
        .divisor  (mag_reg),
        .quotient (div_q),
        .stat     (div_stat)
    );

    // datapath decisions
    always_comb
    begin
        mag_in   = sample_ch.sample_in[apl_pkg::SAMPLE_W-1]
                   ? (~sample_ch.sample_in + 1'b1) : sample_ch.sample_in;
        ceil_hit = (mul0_prod > {3'b000, ceil_reg, {FW{1'b0}}});
        thr_hit  = ({1'b0, thr_reg} < mag_reg) && (g_reg == apl_pkg::UNITY_GAIN);
        // c*g + (1 - c) with c in Q0.16 and g in Q1.16, taken back down by 16 bits
        rel_sum  = mul1_prod
                   + {1'b0, apl_pkg::UNITY_GAIN - {1'b0, rel_reg}, {FW{1'b0}}};
        rel_q    = rel_sum[PROD_W-1:FW];
        rel_gain = (rel_q > {1'b0, apl_pkg::UNITY_GAIN})
                   ? apl_pkg::UNITY_GAIN : rel_q[apl_pkg::GAIN_W-1:0];
        floor_g  = (ming_reg > apl_pkg::UNITY_GAIN) ? apl_pkg::UNITY_GAIN : ming_reg;
        floored  = (gsel_reg < floor_g) ? floor_g : gsel_reg;
        scaled   = mul0_prod[FW+apl_pkg::GAIN_W-1:FW];
        if (neg_reg)
        begin
            if (scaled > apl_pkg::GAIN_W'(32768))
                y_sat = 16'sh8000;
            else
                y_sat = apl_pkg::SAMPLE_W'(~scaled + 1'b1);
        end
        else
        begin
            if (scaled > apl_pkg::GAIN_W'(32767))
                y_sat = 16'sh7fff;
            else
                y_sat = scaled[apl_pkg::SAMPLE_W-1:0];
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= apl_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        mul0_start      = 1'b0;
        mul1_start      = 1'b0;
        div_start       = 1'b0;
        emit            = 1'b0;
        sample_ch.ready = 1'b0;
        case (state_reg)
            apl_pkg::ST_IDLE:
            begin
                sample_ch.ready = 1'b1;
                if (sample_ch.valid)
                    state_next = apl_pkg::ST_M1_GO;
            end
            apl_pkg::ST_M1_GO:
            begin
                mul0_start = 1'b1;
                mul1_start = 1'b1;
                state_next = apl_pkg::ST_M1_WAIT;
            end
            apl_pkg::ST_M1_WAIT:
            begin
                if (mul0_stat.done)
                    state_next = apl_pkg::ST_DECIDE;
            end
            apl_pkg::ST_DECIDE:
            begin
                if (ceil_hit || thr_hit)
                    state_next = apl_pkg::ST_DIV_GO;
                else
                    state_next = apl_pkg::ST_FLOOR;
            end
            apl_pkg::ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = apl_pkg::ST_DIV_WAIT;
            end
            apl_pkg::ST_DIV_WAIT:
            begin
                if (div_stat.done)
                    state_next = apl_pkg::ST_FLOOR;
            end
            apl_pkg::ST_FLOOR:
            begin
                state_next = apl_pkg::ST_M2_GO;
            end
            apl_pkg::ST_M2_GO:
            begin
                mul0_start = 1'b1;
                state_next = apl_pkg::ST_M2_WAIT;
            end
            apl_pkg::ST_M2_WAIT:
            begin
                if (mul0_stat.done)
                    state_next = apl_pkg::ST_EMIT;
            end
            apl_pkg::ST_EMIT:
            begin
                // wait here only if the previous result has not been taken
                if (!out_valid_reg || result_ch.ready)
                begin
                    emit       = 1'b1;
                    state_next = apl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = apl_pkg::ST_IDLE;
            end
        endcase
    end

    assign accept = sample_ch.valid && sample_ch.ready;

    // configuration and gain state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= apl_pkg::THRESHOLD_RESET;
            ceil_reg     <= apl_pkg::CEILING_RESET;
            rel_reg      <= apl_pkg::RELEASE_RESET;
            ming_reg     <= apl_pkg::MIN_GAIN_RESET;
            cur_gain_reg <= apl_pkg::UNITY_GAIN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    apl_pkg::CFG_THRESHOLD: thr_reg  <= cfg_data[apl_pkg::LEVEL_W-1:0];
                    apl_pkg::CFG_CEILING:   ceil_reg <= cfg_data[apl_pkg::LEVEL_W-1:0];
                    apl_pkg::CFG_RELEASE:   rel_reg  <= cfg_data[apl_pkg::COEFF_W-1:0];
                    apl_pkg::CFG_MIN_GAIN:  ming_reg <= cfg_data[apl_pkg::GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == apl_pkg::ST_FLOOR)
                cur_gain_reg <= floored;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (result_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // per-sample payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mag_reg <= mag_in;
            neg_reg <= sample_ch.sample_in[apl_pkg::SAMPLE_W-1];
            g_reg   <= sample_ch.frame_start ? apl_pkg::UNITY_GAIN : cur_gain_reg;
        end
        if (state_reg == apl_pkg::ST_DECIDE)
        begin
            level_reg <= ceil_hit ? ceil_reg : thr_reg;
            gsel_reg  <= rel_gain;
        end
        if (div_stat.done && (state_reg == apl_pkg::ST_DIV_WAIT))
            gsel_reg <= {1'b0, div_q};
        if (state_reg == apl_pkg::ST_FLOOR)
            g_reg <= floored;
        if (emit)
        begin
            out_sample_reg <= y_sat;
            out_gain_reg   <= g_reg;
        end
    end

    assign result_ch.valid      = out_valid_reg;
    assign result_ch.sample_out = out_sample_reg;
    assign result_ch.gain_out   = out_gain_reg;

    `APL_ASSERT_NOW(a_gain_le_unity, 1'b1, cur_gain_reg <= apl_pkg::UNITY_GAIN,
        "stored gain above unity")
    `APL_ASSERT_NOW(a_div_level_below_mag, state_reg == apl_pkg::ST_DIV_GO,
        ({1'b0, level_reg} < mag_reg), "divider started with level not below magnitude")
    `APL_ASSERT_NOW(a_muls_in_step,
        (state_reg == apl_pkg::ST_M1_WAIT) && mul0_stat.done, mul1_stat.done,
        "release multiplier out of step")
    `APL_ASSERT_NOW(a_idle_units_quiet, state_reg == apl_pkg::ST_IDLE,
        !mul0_stat.busy && !mul1_stat.busy && !div_stat.busy,
        "arithmetic unit busy while idle")
    `APL_ASSERT_NEXT(a_emit_gain_floored, emit, result_ch.gain_out >= floor_g,
        "emitted gain below floor")

endmodule

// ===== hdl/apl_serial_mul.sv =====
// Shift-add serial multiplier, one multiplier bit per cycle.
module apl_serial_mul (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [apl_pkg::MUL_W-1:0]          op_a,
    input  logic [apl_pkg::MUL_W-1:0]          op_b,
    output logic [2*apl_pkg::MUL_W-1:0]        product,
    output apl_pkg::unit_stat_t                stat
);

    logic [apl_pkg::MUL_W-1:0]     a_reg;
    logic [apl_pkg::MUL_W-1:0]     hi_reg;
    logic [apl_pkg::MUL_W-1:0]     lo_reg;
    logic [apl_pkg::MUL_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [apl_pkg::MUL_W:0]       sum;
    logic                          last;

    always_comb
    begin
        if (lo_reg[0])
            sum = {1'b0, hi_reg} + {1'b0, a_reg};
        else
            sum = {1'b0, hi_reg};
        last = (cnt_reg == apl_pkg::MUL_CNT_W'(apl_pkg::MUL_STEPS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // low half starts as the multiplier and fills with product bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= op_a;
            hi_reg <= '0;
            lo_reg <= op_b;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[apl_pkg::MUL_W:1];
            lo_reg <= {sum[0], lo_reg[apl_pkg::MUL_W-1:1]};
        end
    end

    assign product   = {hi_reg, lo_reg};
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== hdl/apl_serial_div.sv =====
// Restoring serial divider of level * 2^16 by a larger magnitude, one bit per cycle.
module apl_serial_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [apl_pkg::LEVEL_W-1:0]    level,
    input  logic [apl_pkg::DIV_W-1:0]      divisor,
    output logic [apl_pkg::DIV_W-1:0]      quotient,
    output apl_pkg::unit_stat_t            stat
);

    logic [apl_pkg::DIV_W-1:0]     d_reg;
    logic [apl_pkg::DIV_W-1:0]     rem_reg;
    logic [apl_pkg::DIV_W-1:0]     q_reg;
    logic [apl_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [apl_pkg::DIV_W:0]       shifted;
    logic [apl_pkg::DIV_W:0]       diff;
    logic                          ge;
    logic                          last;

    // level < divisor, so the remainder always fits in DIV_W bits
    always_comb
    begin
        shifted = {rem_reg, 1'b0};
        diff    = shifted - {1'b0, d_reg};
        ge      = (shifted >= {1'b0, d_reg});
        last    = (cnt_reg == apl_pkg::DIV_CNT_W'(apl_pkg::DIV_STEPS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            d_reg   <= divisor;
            rem_reg <= {1'b0, level};
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[apl_pkg::DIV_W-1:0] : shifted[apl_pkg::DIV_W-1:0];
            q_reg   <= {q_reg[apl_pkg::DIV_W-2:0], ge};
        end
    end

    assign quotient  = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== tb/audio_peak_limiter_unit_test.sv =====
// Self-checking testbench for the audio peak limiter: random and directed samples with scoreboard.
`timescale 1ns / 100ps

typedef struct packed {
    logic signed [apl_pkg::SAMPLE_W-1:0] sample;
    logic        [apl_pkg::GAIN_W-1:0]   gain;
} limited_t;

class limiter_scoreboard;
    logic [apl_pkg::LEVEL_W-1:0] threshold;
    logic [apl_pkg::LEVEL_W-1:0] ceiling;
    logic [apl_pkg::COEFF_W-1:0] rel_coeff;
    logic [apl_pkg::GAIN_W-1:0]  gain_floor;
    logic [apl_pkg::GAIN_W-1:0]  gain;
    limited_t                    limited_q[$];
    int                          errors;

    function new();
        threshold  = apl_pkg::THRESHOLD_RESET;
        ceiling    = apl_pkg::CEILING_RESET;
        rel_coeff  = apl_pkg::RELEASE_RESET;
        gain_floor = apl_pkg::MIN_GAIN_RESET;
        gain       = apl_pkg::UNITY_GAIN;
        errors     = 0;
    endfunction

    function void write_reg(logic [apl_pkg::CFG_IDX_W-1:0] idx,
                            logic [apl_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            apl_pkg::CFG_THRESHOLD: threshold  = data[apl_pkg::LEVEL_W-1:0];
            apl_pkg::CFG_CEILING:   ceiling    = data[apl_pkg::LEVEL_W-1:0];
            apl_pkg::CFG_RELEASE:   rel_coeff  = data[apl_pkg::COEFF_W-1:0];
            apl_pkg::CFG_MIN_GAIN:  gain_floor = data[apl_pkg::GAIN_W-1:0];
            default: ;
        endcase
    endfunction

    function void flag(string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endfunction

    function int pending();
        return limited_q.size();
    endfunction

    // works out the limited sample and the gain for one accepted transfer
    function void take_sample(logic signed [apl_pkg::SAMPLE_W-1:0] x, logic fs);
        logic [63:0] mag;
        logic [63:0] g;
        logic [63:0] ceil_q;
        logic [63:0] thr_q;
        logic [63:0] target;
        logic [63:0] floor_g;
        logic [63:0] scaled;
        limited_t    r;
        mag = x[apl_pkg::SAMPLE_W-1] ? 64'd65536 - {48'd0, x} : {48'd0, x};
        if (fs)
            gain = apl_pkg::UNITY_GAIN;
        g      = 64'(gain);
        ceil_q = 64'(ceiling) << apl_pkg::FRAC_W;
        thr_q  = 64'(threshold) << apl_pkg::FRAC_W;
        if (mag * g > ceil_q) begin
            g = ceil_q / mag;
        end
        else if (mag > 64'(threshold) && g >= 64'(apl_pkg::UNITY_GAIN)) begin
            target = thr_q / mag;
            if (target < g)
                g = target;
        end
        else begin
            g = (64'(rel_coeff) * g
                 + (64'(apl_pkg::UNITY_GAIN) - 64'(rel_coeff)) * 64'(apl_pkg::UNITY_GAIN))
                >> apl_pkg::FRAC_W;
            if (g > 64'(apl_pkg::UNITY_GAIN))
                g = 64'(apl_pkg::UNITY_GAIN);
        end
        // floor values above unity act as unity
        floor_g = (gain_floor > apl_pkg::UNITY_GAIN) ? 64'(apl_pkg::UNITY_GAIN)
                                                     : 64'(gain_floor);
        if (g < floor_g)
            g = floor_g;
        gain   = g[apl_pkg::GAIN_W-1:0];
        scaled = (mag * 64'(gain)) >> apl_pkg::FRAC_W;
        if (x[apl_pkg::SAMPLE_W-1])
            r.sample = (scaled > 64'd32768) ? 16'sh8000 : 16'(64'd0 - scaled);
        else
            r.sample = (scaled > 64'd32767) ? 16'sh7fff : 16'(scaled);
        r.gain = gain;
        limited_q.push_back(r);
    endfunction

    function void match_result(logic signed [apl_pkg::SAMPLE_W-1:0] s,
                               logic [apl_pkg::GAIN_W-1:0] gn);
        limited_t want;
        if (limited_q.size() == 0) begin
            flag($sformatf("unexpected result: sample_out %0d gain_out %0d", s, gn));
            return;
        end
        want = limited_q.pop_front();
        if (s !== want.sample)
            flag($sformatf("sample_out mismatch: expected %0d, actual %0d", want.sample, s));
        if (gn !== want.gain)
            flag($sformatf("gain_out mismatch: expected %0d, actual %0d", want.gain, gn));
    endfunction
endclass

module audio_peak_limiter_unit_test;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEM_TARGET    = 650;
    localparam int PHASE_ITEMS    = 80;
    localparam int DRAIN_CYCLES   = 80;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [apl_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [apl_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           calm;
    int                             stall_left;
    int                             idle_cycles;
    int                             sent;

    limiter_scoreboard board = new();

    apl_in_if  sample_bus();
    apl_out_if result_bus();

    audio_peak_limiter_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_bus),
        .result_ch (result_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // register writes and transfers on both channels feed the scoreboard
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (cfg_we)
                board.write_reg(cfg_index, cfg_data);
            if (sample_bus.valid && sample_bus.ready)
                board.take_sample(sample_bus.sample_in, sample_bus.frame_start);
            if (result_bus.valid && result_bus.ready)
                board.match_result(result_bus.sample_out, result_bus.gain_out);
        end
    end

    // result-side backpressure: none while calm, else mostly short stalls, a few long ones
    always @(posedge clk)
    begin
        if (!rst_n) begin
            result_bus.ready <= 1'b0;
            stall_left       <= 0;
        end
        else if (calm) begin
            result_bus.ready <= 1'b1;
        end
        else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 3) != 0) begin
            result_bus.ready <= 1'b1;
            stall_left       <= $urandom_range(0, 15);
        end
        else begin
            result_bus.ready <= 1'b0;
            stall_left       <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80)
                                                            : $urandom_range(0, 3);
        end
    end

    always @(posedge clk)
    begin
        if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("audio_peak_limiter_unit_test: done, errors");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 15);
        if (r < 9)
            return 0;
        if (r < 14)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [apl_pkg::SAMPLE_W-1:0] pick_sample(int thr);
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (r < 4)
            v = thr + $urandom_range(0, 2000) - 500;
        else if (r < 7)
            return apl_pkg::SAMPLE_W'($urandom);
        else if (r < 9)
            v = $urandom_range(0, 255);
        else begin
            case ($urandom_range(0, 3))
                0:       return 16'sh7fff;
                1:       return 16'sh8000;
                2:       return 16'sh0000;
                default: return 16'shffff;
            endcase
        end
        if ($urandom_range(0, 1) == 1)
            v = -v;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return apl_pkg::SAMPLE_W'(v);
    endfunction

    // all driving tasks are entered right after a rising edge
    task automatic send_sample(input logic signed [apl_pkg::SAMPLE_W-1:0] s, input logic fs);
        int n;
        n = gap_len();
        if (n > 0) begin
            sample_bus.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        sample_bus.valid       <= 1'b1;
        sample_bus.sample_in   <= s;
        sample_bus.frame_start <= fs;
        do
            @(posedge clk);
        while (!sample_bus.ready);
        sent++;
    endtask

    // the scoreboard sees the last transfer before the first check
    task automatic wait_drained();
        sample_bus.valid <= 1'b0;
        @(negedge clk);
        while (board.pending() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [apl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [apl_pkg::CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [apl_pkg::CFG_DATA_W-1:0] thr,
                            input logic [apl_pkg::CFG_DATA_W-1:0] ceil_lvl,
                            input logic [apl_pkg::CFG_DATA_W-1:0] rel,
                            input logic [apl_pkg::CFG_DATA_W-1:0] mg);
        wait_drained();
        write_reg(apl_pkg::CFG_THRESHOLD, thr);
        write_reg(apl_pkg::CFG_CEILING, ceil_lvl);
        write_reg(apl_pkg::CFG_RELEASE, rel);
        write_reg(apl_pkg::CFG_MIN_GAIN, mg);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int     thr;
        int     ceil_lvl;
        int     rel;
        longint mg;
        int     phase_cnt;
        int     frame_len;
        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_index              <= apl_pkg::CFG_THRESHOLD;
        cfg_data               <= '0;
        calm                   <= 1'b0;
        sample_bus.valid       <= 1'b0;
        sample_bus.sample_in   <= '0;
        sample_bus.frame_start <= 1'b0;
        sent = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: full-scale peaks only graze the ceiling
        send_sample(16'sd0, 1'b1);
        send_sample(16'sd32767, 1'b0);
        send_sample(-16'sd32768, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd1, 1'b0);
        send_sample(16'sd16384, 1'b1);

        // ceiling hit, then release from a reduced gain
        set_regs(17'd8192, 17'd16384, 17'd60000, 17'd32768);
        send_sample(16'sd20000, 1'b1);
        send_sample(16'sd32767, 1'b0);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(-16'sd9000, 1'b0);
        send_sample(-16'sd32768, 1'b1);

        // zero threshold, release coefficient zero snaps back to unity
        set_regs(17'd0, 17'd32767, 17'd0, 17'd1000);
        send_sample(16'sd5, 1'b1);
        send_sample(-16'sd7, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd32767, 1'b0);

        // masked threshold write, zero ceiling, floor above unity
        set_regs(17'h1ffff, 17'd0, 17'd65535, 17'h1ffff);
        send_sample(16'sd123, 1'b1);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd0, 1'b0);

        // ceiling hit with slowest release and no floor
        set_regs(17'd4000, 17'd2000, 17'd65535, 17'd0);
        send_sample(16'sd30000, 1'b1);
        send_sample(16'sd100, 1'b0);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd0, 1'b1);

        while (sent < ITEM_TARGET) begin
            case ($urandom_range(0, 7))
                0:       thr = 0;
                1:       thr = 32767;
                default: thr = $urandom_range(0, 32767);
            endcase
            case ($urandom_range(0, 7))
                0:       ceil_lvl = 0;
                1:       ceil_lvl = 32767;
                2:       ceil_lvl = thr / 2;
                default: ceil_lvl = $urandom_range(0, 32767);
            endcase
            case ($urandom_range(0, 9))
                0:       rel = 0;
                1:       rel = 65535;
                2, 3:    rel = $urandom_range(0, 65535);
                default: rel = $urandom_range(64000, 65535);
            endcase
            if ($urandom_range(0, 3) == 0)
                mg = $urandom_range(0, 131071);
            else if (thr == 0)
                mg = 0;
            else
                mg = (longint'(ceil_lvl) * 65536) / thr;
            if (mg > 131071)
                mg = 131071;
            // upper data bits beyond each register's width are noise
            set_regs({2'($urandom), 15'(thr)}, {2'($urandom), 15'(ceil_lvl)},
                     {1'($urandom), 16'(rel)}, 17'(mg));
            calm <= ($urandom_range(0, 3) == 0);
            phase_cnt = 0;
            while (phase_cnt < PHASE_ITEMS) begin
                frame_len = $urandom_range(4, 40);
                for (int k = 0; k < frame_len; k++) begin
                    send_sample(pick_sample(thr), (k == 0) || ($urandom_range(0, 31) == 0));
                    phase_cnt++;
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.pending() != 0)
            board.flag($sformatf("%0d results never arrived", board.pending()));
        if (board.errors == 0)
            $display("audio_peak_limiter_unit_test: done, clean");
        else
            $display("audio_peak_limiter_unit_test: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/apl_pkg.sv
hdl/apl_in_if.sv
hdl/apl_out_if.sv
hdl/apl_serial_mul.sv
hdl/apl_serial_div.sv
hdl/audio_peak_limiter_unit.sv
tb/audio_peak_limiter_unit_test.sv
